/* hw/rtl/ezr_pkg.sv */
`timescale 1ns / 1ps
package ezr_pkg;
   localparam int ANGLE_FRAC_BITS_DEF = 13;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int WFRAC = 30;
   localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;

   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rsp_type;

   function automatic logic signed [35:0] atan_q30(input int i);
      logic [31:0] t [32];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
            32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
            32'h00000001, 32'h00000000};
      return $signed({4'd0, t[i & 31]});
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] nin);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] b;
      n = nin;
      res = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > n) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (n >= res + b) begin
               n = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
      end
      return res;
   endfunction

   // square root of the cordic gain squared, scaled to q30
   function automatic logic [63:0] gain_root(input int steps);
      logic [63:0] p;
      logic [63:0] a;
      p = 64'd1 << WFRAC;
      for (int i = 0; i < 32; i++) begin
         if (i < steps) p = p + (p >> (2 * i));
      end
      a = isqrt64(p << WFRAC);
      if (a == 0) a = 1;
      return a;
   endfunction

   function automatic logic signed [35:0] rnd_mul(input logic signed [35:0] a,
                                                  input logic signed [35:0] b);
      logic signed [71:0] p;
      p = a * b + (72'sd1 <<< (WFRAC - 1));
      return 36'(p >>> WFRAC);
   endfunction
endpackage

/* hw/rtl/euler_zyx_rotation_matrix_unit.sv */
`timescale 1ns / 1ps
// channel   ports                          direction
// request   start, req_data                in; busy is out
// response  rsp_valid, rsp_data            out
// one item per cycle; busy is always low
// pipeline: range reduce register, cordic stages, three merge stages
// synchronous reset clears only the valid pipeline
// the receiver cannot stall; every result shows for one cycle
module euler_zyx_rotation_matrix_unit #(
   parameter int ANGLE_FRAC_BITS = ezr_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int COEF_FRAC_BITS = ezr_pkg::COEF_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = ezr_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  ezr_pkg::req_type req_data,
   output logic rsp_valid,
   output ezr_pkg::rsp_type rsp_data
);
   import ezr_pkg::*;

   localparam int LAT = CORDIC_STEPS + 4;

   logic signed [35:0] sx, cx, sy, cy, sz, cz;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   ezr_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lx (
      .clock(clock), .angle(req_data.angle_x), .sin_q(sx), .cos_q(cx));
   ezr_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_ly (
      .clock(clock), .angle(req_data.angle_y), .sin_q(sy), .cos_q(cy));
   ezr_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lz (
      .clock(clock), .angle(req_data.angle_z), .sin_q(sz), .cos_q(cz));

   ezr_merge #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_merge (
      .clock(clock), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
      .result(rsp_data));

   assign busy = 1'b0;
   assign vld_in = {vld_ff[LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];
endmodule

/* hw/rtl/ezr_lane.sv */
`timescale 1ns / 1ps
module ezr_lane #(
   parameter int ANGLE_FRAC_BITS = ezr_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = ezr_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic signed [15:0] angle,
   output logic signed [35:0] sin_q,
   output logic signed [35:0] cos_q
);
   import ezr_pkg::*;
   localparam logic [63:0] GAIN_ROOT = gain_root(CORDIC_STEPS);
   localparam logic signed [35:0] KINV = 36'((64'd1 << 60) / GAIN_ROOT);

   logic signed [35:0] z0_in, z0_ff;
   logic neg0_ff;
   logic neg0_in;
   logic signed [35:0] x_ff [CORDIC_STEPS+1];
   logic signed [35:0] y_ff [CORDIC_STEPS+1];
   logic signed [35:0] z_ff [CORDIC_STEPS+1];
   logic neg_ff [CORDIC_STEPS+1];

   // range reduction into [-pi/2, pi/2]
   always_comb begin
      logic signed [35:0] z;
      z = 36'(angle) <<< (WFRAC - ANGLE_FRAC_BITS);
      neg0_in = 1'b0;
      if (z > PI_Q30) z = z - TWO_PI_Q30;
      if (z < -PI_Q30) z = z + TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
         z = PI_Q30 - z;
         neg0_in = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z = -PI_Q30 - z;
         neg0_in = 1'b1;
      end
      z0_in = z;
   end

   always_ff @(posedge clock) begin
      z0_ff <= z0_in;
      neg0_ff <= neg0_in;
   end

   always_comb begin
      x_ff[0] = KINV;
      y_ff[0] = '0;
      z_ff[0] = z0_ff;
      neg_ff[0] = neg0_ff;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_q30(i);
         end
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   assign sin_q = y_ff[CORDIC_STEPS];
   assign cos_q = neg_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
endmodule

/* hw/rtl/ezr_merge.sv */
`timescale 1ns / 1ps
module ezr_merge #(
   parameter int COEF_FRAC_BITS = ezr_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic signed [35:0] sx, cx, sy, cy, sz, cz,
   output ezr_pkg::rsp_type result
);
   import ezr_pkg::*;

   logic signed [35:0] czsy_ff, szsy_ff, czcy_ff, szcy_ff, cysx_ff, cycx_ff;
   logic signed [35:0] szcx_ff, szsx_ff, czcx_ff, czsx_ff, nsy_ff, sx1_ff, cx1_ff;
   logic signed [35:0] a01_ff, a02_ff, a11_ff, a12_ff;
   logic signed [35:0] b00_ff, b10_ff, b20_ff, b21_ff, b22_ff;

   function automatic logic signed [15:0] to_coef(input logic signed [36:0] v);
      logic signed [36:0] r;
      logic signed [36:0] lim;
      r = (v + (37'sd1 <<< (WFRAC - COEF_FRAC_BITS - 1))) >>> (WFRAC - COEF_FRAC_BITS);
      lim = 37'sd1 <<< COEF_FRAC_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      if (r > 37'sd32767) r = 37'sd32767;
      if (r < -37'sd32768) r = -37'sd32768;
      return r[15:0];
   endfunction

   always_ff @(posedge clock) begin
      czsy_ff <= rnd_mul(cz, sy);
      szsy_ff <= rnd_mul(sz, sy);
      czcy_ff <= rnd_mul(cz, cy);
      szcy_ff <= rnd_mul(sz, cy);
      cysx_ff <= rnd_mul(cy, sx);
      cycx_ff <= rnd_mul(cy, cx);
      szcx_ff <= rnd_mul(sz, cx);
      szsx_ff <= rnd_mul(sz, sx);
      czcx_ff <= rnd_mul(cz, cx);
      czsx_ff <= rnd_mul(cz, sx);
      nsy_ff <= -sy;
      sx1_ff <= sx;
      cx1_ff <= cx;

      a01_ff <= rnd_mul(czsy_ff, sx1_ff) - szcx_ff;
      a02_ff <= rnd_mul(czsy_ff, cx1_ff) + szsx_ff;
      a11_ff <= rnd_mul(szsy_ff, sx1_ff) + czcx_ff;
      a12_ff <= rnd_mul(szsy_ff, cx1_ff) - czsx_ff;
      b00_ff <= czcy_ff;
      b10_ff <= szcy_ff;
      b20_ff <= nsy_ff;
      b21_ff <= cysx_ff;
      b22_ff <= cycx_ff;

      result.m00 <= to_coef(37'(b00_ff));
      result.m01 <= to_coef(37'(a01_ff));
      result.m02 <= to_coef(37'(a02_ff));
      result.m10 <= to_coef(37'(b10_ff));
      result.m11 <= to_coef(37'(a11_ff));
      result.m12 <= to_coef(37'(a12_ff));
      result.m20 <= to_coef(37'(b20_ff));
      result.m21 <= to_coef(37'(b21_ff));
      result.m22 <= to_coef(37'(b22_ff));
   end
endmodule

/* hw/rtl/ezr_checker.sv */
`timescale 1ns / 1ps
module ezr_checker #(
   parameter int LAT = 20
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT)) else $error("result without item");
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind euler_zyx_rotation_matrix_unit ezr_checker #(.LAT(CORDIC_STEPS + 4)) u_ezr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid));

/* sim/euler_zyx_rotation_matrix_unit_tb.sv */
`timescale 1ns / 1ps
module euler_zyx_rotation_matrix_unit_tb;
   import ezr_pkg::*;

   localparam int AFB = ANGLE_FRAC_BITS_DEF;
   localparam int CFB = COEF_FRAC_BITS_DEF;
   localparam int STEPS = CORDIC_STEPS_DEF;
   localparam int LATENCY = STEPS + 4;
   localparam int ANGLE_MAX = 25736;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;

   rsp_type matrix_queue[$];
   int errors = 0;
   int items_sent = 0;
   int matrices_seen = 0;

   euler_zyx_rotation_matrix_unit i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint shift_right(longint v, int s);
      if (v < 0) return ~((~v) >>> s);
      return v >>> s;
   endfunction

   function automatic longint round_q(longint v, int s);
      if (s == 0) return v;
      return shift_right(v + (64'sd1 <<< (s - 1)), s);
   endfunction

   function automatic longint mul30(longint a, longint b);
      return round_q(a * b, WFRAC);
   endfunction

   function automatic longint root64(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint inverse_gain();
      longint unsigned p;
      longint unsigned a;
      p = 64'd1 << WFRAC;
      for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
      a = root64(p << WFRAC);
      if (a == 0) a = 1;
      return longint'((64'd1 << 60) / a);
   endfunction

   function automatic longint arctan(int i);
      longint t[32];
      t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
            64'h00000001, 64'h00000000};
      return t[i & 31];
   endfunction

   task automatic sine_cosine(input logic signed [15:0] ang, output longint s,
                              output longint c);
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      longint pi;
      longint hpi;
      longint tpi;
      bit flip;
      pi = longint'(PI_Q30);
      hpi = longint'(HALF_PI_Q30);
      tpi = longint'(TWO_PI_Q30);
      flip = 0;
      z = longint'(ang) * (64'sd1 <<< (WFRAC - AFB));
      z = z % tpi;
      if (z > pi) z = z - tpi;
      if (z < -pi) z = z + tpi;
      if (z > hpi) begin
         z = pi - z;
         flip = 1;
      end else if (z < -hpi) begin
         z = -pi - z;
         flip = 1;
      end
      x = inverse_gain();
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = shift_right(y, i);
         dy = shift_right(x, i);
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan(i);
         end
      end
      s = y;
      c = flip ? -x : x;
   endtask

   function automatic logic signed [15:0] to_coefficient(longint v);
      longint r;
      longint lim;
      r = round_q(v, WFRAC - CFB);
      lim = 64'sd1 <<< CFB;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   task automatic predict_matrix(input req_type a, output rsp_type m);
      longint sx, cx, sy, cy, sz, cz, czsy, szsy;
      sine_cosine(a.angle_x, sx, cx);
      sine_cosine(a.angle_y, sy, cy);
      sine_cosine(a.angle_z, sz, cz);
      czsy = mul30(cz, sy);
      szsy = mul30(sz, sy);
      m.m00 = to_coefficient(mul30(cz, cy));
      m.m01 = to_coefficient(mul30(czsy, sx) - mul30(sz, cx));
      m.m02 = to_coefficient(mul30(czsy, cx) + mul30(sz, sx));
      m.m10 = to_coefficient(mul30(sz, cy));
      m.m11 = to_coefficient(mul30(szsy, sx) + mul30(cz, cx));
      m.m12 = to_coefficient(mul30(szsy, cx) - mul30(cz, sx));
      m.m20 = to_coefficient(-sy);
      m.m21 = to_coefficient(mul30(cy, sx));
      m.m22 = to_coefficient(mul30(cy, cx));
   endtask

   task automatic check_field(string name, logic signed [15:0] want,
                              logic signed [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         matrices_seen++;
         if (matrix_queue.size() == 0) begin
            $error("matrix with no item pending");
            errors++;
         end else begin
            want = matrix_queue.pop_front();
            check_field("m00", want.m00, rsp_data.m00);
            check_field("m01", want.m01, rsp_data.m01);
            check_field("m02", want.m02, rsp_data.m02);
            check_field("m10", want.m10, rsp_data.m10);
            check_field("m11", want.m11, rsp_data.m11);
            check_field("m12", want.m12, rsp_data.m12);
            check_field("m20", want.m20, rsp_data.m20);
            check_field("m21", want.m21, rsp_data.m21);
            check_field("m22", want.m22, rsp_data.m22);
         end
      end
   end

   // start held high across back-to-back items
   task automatic send_angles(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic signed [15:0] az, input int gap);
      req_type a;
      rsp_type m;
      a.angle_x = ax;
      a.angle_y = ay;
      a.angle_z = az;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= a;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_matrix(a, m);
      matrix_queue.push_back(m);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic signed [15:0] random_angle();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'($urandom());
      if (r == 1) return 16'($signed($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
      return 16'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
   endfunction

   task automatic test_extremes();
      logic signed [15:0] v[10];
      v = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868, 16'sd32767,
            -16'sd32768, 16'sd6434, -16'sd1, 16'sd1};
      for (int i = 0; i < 8; i++) send_angles(v[i], 16'sd0, 16'sd0, 0);
      for (int i = 0; i < 8; i++) send_angles(16'sd0, v[i], v[9 - i], 0);
      for (int i = 0; i < 8; i++) send_angles(v[i], v[(i + 3) % 10], v[(i + 5) % 10], 1);
   endtask

   task automatic test_random_stream(int n);
      for (int i = 0; i < n; i++)
         send_angles(random_angle(), random_angle(), random_angle(), random_gap());
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (matrix_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   initial begin
      #2000000;
      $display("euler_zyx_rotation_matrix_unit regression: fail");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_random_stream(530);
      drain_results();
      $display("sent %0d angle triples, checked %0d matrices", items_sent, matrices_seen);
      if (errors == 0 && matrix_queue.size() == 0) begin
         $display("euler_zyx_rotation_matrix_unit regression: pass");
      end else begin
         $display("euler_zyx_rotation_matrix_unit regression: fail");
      end
      $finish;
   end
endmodule

/* euler_zyx_rotation_matrix_unit.f */
hw/rtl/ezr_pkg.sv
hw/rtl/ezr_lane.sv
hw/rtl/ezr_merge.sv
hw/rtl/euler_zyx_rotation_matrix_unit.sv
hw/rtl/ezr_checker.sv
sim/euler_zyx_rotation_matrix_unit_tb.sv
